// ===== rtl/wmm_pkg.sv =====
package wmm_pkg;

  localparam int MASK_MAX = 32;
  localparam int LEN_W    = $clog2(MASK_MAX + 1);
  localparam int IDX_W    = $clog2(MASK_MAX);
  localparam int CLOSE_LVLS = $clog2(MASK_MAX + 1);

  localparam logic [7:0] CHAR_STAR      = 8'h2A;
  localparam logic [7:0] CHAR_ANY       = 8'h3F;
  localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
  localparam logic [7:0] CHAR_UPPER_A   = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z   = 8'h5A;
  localparam logic [7:0] CASE_OFFSET    = 8'h20;

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_APPEND  = 2'd1,
    OP_SUBJECT = 2'd2,
    OP_EMPTY   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_LIT  = 2'd0,
    KIND_ANY  = 2'd1,
    KIND_STAR = 2'd2
  } kind_t;

  typedef logic [MASK_MAX:0]   pos_vec_t;
  typedef logic [MASK_MAX-1:0] elem_vec_t;

  // Fold A-Z onto a-z when case folding is enabled.
  function automatic logic [7:0] fold(input logic fold_en, input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (fold_en && c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      r = c + CASE_OFFSET;
    end
    return r;
  endfunction

  // A reached star position also reaches the next one; runs of stars are
  // closed with a log-depth prefix network.
  function automatic pos_vec_t star_close(input pos_vec_t v, input elem_vec_t p);
    pos_vec_t g;
    pos_vec_t pp;
    pos_vec_t g_n;
    pos_vec_t pp_n;
    int d;
    g  = v;
    pp = {p, 1'b0};
    for (int l = 0; l < CLOSE_LVLS; l++) begin
      d    = 1 << l;
      g_n  = g;
      pp_n = '0;
      for (int j = 0; j <= MASK_MAX; j++) begin
        if (j >= d) begin
          g_n[j]  = g[j] | (pp[j] & g[j-d]);
          pp_n[j] = pp[j] & pp[j-d];
        end
      end
      g  = g_n;
      pp = pp_n;
    end
    return g;
  endfunction

endpackage

// ===== rtl/wmm_if.sv =====
interface wmm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] char_byte;
  logic       is_last;

  modport source (output valid, output op, output char_byte, output is_last, input ready);
  modport sink   (input valid, input op, input char_byte, input is_last, output ready);
endinterface

interface wmm_out_if;
  logic valid;
  logic ready;
  logic matched;
  logic pattern_overflow;

  modport source (output valid, output matched, output pattern_overflow, input ready);
  modport sink   (input valid, input matched, input pattern_overflow, output ready);
endinterface

// ===== rtl/wildcard_mask_matcher_core.sv =====
// The result on out_ch is registered: it appears in the cycle after the transaction carrying
// the last subject byte (or an empty-subject op) is accepted.
// Throughput: one input transaction per cycle while out_ch does not hold a result back; each
// subject byte updates all mask positions in parallel through a single register stage.
// Reset (rst_n, synchronous): clears mask length, escape, overflow, subject
// state, the case-folding register and the result valid; mask bytes stay
// undefined until written.
module wildcard_mask_matcher_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic            cfg_wdata,
  wmm_in_if.sink          in_ch,
  wmm_out_if.source       out_ch
);

  logic [7:0]                  mask_chars_r [wmm_pkg::MASK_MAX];
  wmm_pkg::kind_t              mask_kinds_r [wmm_pkg::MASK_MAX];
  logic [wmm_pkg::LEN_W-1:0]   mask_len_r, mask_len_nxt;
  wmm_pkg::elem_vec_t          used_r, used_nxt;
  logic                        esc_r, esc_nxt;
  logic                        ovf_r, ovf_nxt;
  wmm_pkg::pos_vec_t           active_r, active_nxt;
  logic                        in_subj_r, in_subj_nxt;
  logic                        fold_en_r;

  logic                        out_valid_r;
  logic                        matched_r, matched_nxt;
  logic                        out_ovf_r;

  logic                        accept;
  logic                        emit;
  logic                        put;
  wmm_pkg::kind_t              put_kind;
  wmm_pkg::op_t                op;
  logic [7:0]                  subj_fold;

  wmm_pkg::elem_vec_t          star_p;
  wmm_pkg::elem_vec_t          stay;
  wmm_pkg::elem_vec_t          move;
  wmm_pkg::pos_vec_t           start_vec;
  wmm_pkg::pos_vec_t           base_vec;
  wmm_pkg::pos_vec_t           stepped;
  wmm_pkg::pos_vec_t           final_vec;

  assign op           = wmm_pkg::op_t'(in_ch.op);
  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign accept       = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.matched          = matched_r;
  assign out_ch.pattern_overflow = out_ovf_r;
  assign subj_fold    = wmm_pkg::fold(fold_en_r, in_ch.char_byte);

  always_comb begin
    for (int i = 0; i < wmm_pkg::MASK_MAX; i++) begin
      star_p[i] = used_r[i] && (mask_kinds_r[i] == wmm_pkg::KIND_STAR);
    end
  end

  // Per-lane transition of the active-position set.
  always_comb begin
    for (int i = 0; i < wmm_pkg::MASK_MAX; i++) begin
      stay[i]   = 1'b0;
      move[i]   = 1'b0;
      if (base_vec[i] && used_r[i]) begin
        case (mask_kinds_r[i])
          wmm_pkg::KIND_STAR: stay[i] = 1'b1;
          wmm_pkg::KIND_ANY:  move[i] = 1'b1;
          default: move[i] = (wmm_pkg::fold(fold_en_r, mask_chars_r[i]) == subj_fold);
        endcase
      end
    end
  end

  assign start_vec = wmm_pkg::star_close(wmm_pkg::pos_vec_t'(1), star_p);
  assign base_vec  = in_subj_r ? active_r : start_vec;
  assign stepped   = {move, 1'b0} | {1'b0, stay};
  assign final_vec = (op == wmm_pkg::OP_EMPTY) ? start_vec
                                               : wmm_pkg::star_close(stepped, star_p);

  always_comb begin
    mask_len_nxt = mask_len_r;
    used_nxt     = used_r;
    esc_nxt      = esc_r;
    ovf_nxt      = ovf_r;
    active_nxt   = active_r;
    in_subj_nxt  = in_subj_r;
    emit         = 1'b0;
    put          = 1'b0;
    put_kind     = wmm_pkg::KIND_LIT;
    if (accept) begin
      unique case (op)
        wmm_pkg::OP_CLEAR: begin
          mask_len_nxt = '0;
          used_nxt     = '0;
          esc_nxt      = 1'b0;
          ovf_nxt      = 1'b0;
          active_nxt   = '0;
          in_subj_nxt  = 1'b0;
        end
        wmm_pkg::OP_APPEND: begin
          in_subj_nxt = 1'b0;
          active_nxt  = '0;
          if (esc_r) begin
            esc_nxt = 1'b0;
            put     = 1'b1;
          end else if (in_ch.char_byte == wmm_pkg::CHAR_BACKSLASH) begin
            esc_nxt = 1'b1;
          end else if (in_ch.char_byte == wmm_pkg::CHAR_STAR) begin
            put      = 1'b1;
            put_kind = wmm_pkg::KIND_STAR;
          end else if (in_ch.char_byte == wmm_pkg::CHAR_ANY) begin
            put      = 1'b1;
            put_kind = wmm_pkg::KIND_ANY;
          end else begin
            put = 1'b1;
          end
          if (put) begin
            if (mask_len_r == wmm_pkg::LEN_W'(wmm_pkg::MASK_MAX)) begin
              // drop the element, flag overflow
              ovf_nxt = 1'b1;
            end else begin
              mask_len_nxt = mask_len_r + wmm_pkg::LEN_W'(1);
              used_nxt     = {used_r[wmm_pkg::MASK_MAX-2:0], 1'b1};
            end
          end
        end
        wmm_pkg::OP_SUBJECT: begin
          active_nxt  = final_vec;
          emit        = in_ch.is_last;
          in_subj_nxt = !in_ch.is_last;
        end
        wmm_pkg::OP_EMPTY: begin
          active_nxt  = final_vec;
          emit        = 1'b1;
          in_subj_nxt = 1'b0;
        end
        default: begin
        end
      endcase
    end
    matched_nxt = final_vec[mask_len_r] && !esc_r && !ovf_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_len_r  <= '0;
      used_r      <= '0;
      esc_r       <= 1'b0;
      ovf_r       <= 1'b0;
      active_r    <= '0;
      in_subj_r   <= 1'b0;
      fold_en_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      mask_len_r <= mask_len_nxt;
      used_r     <= used_nxt;
      esc_r      <= esc_nxt;
      ovf_r      <= ovf_nxt;
      active_r   <= active_nxt;
      in_subj_r  <= in_subj_nxt;
      if (cfg_we) begin
        fold_en_r <= cfg_wdata;
      end
      if (in_ch.ready) begin
        out_valid_r <= emit;
      end
    end
  end

  // Payload registers: mask store and result fields.
  always_ff @(posedge clk) begin
    if (put && mask_len_r != wmm_pkg::LEN_W'(wmm_pkg::MASK_MAX)) begin
      mask_chars_r[mask_len_r[wmm_pkg::IDX_W-1:0]] <= in_ch.char_byte;
      mask_kinds_r[mask_len_r[wmm_pkg::IDX_W-1:0]] <= put_kind;
    end
    if (emit) begin
      matched_r <= matched_nxt;
      out_ovf_r <= ovf_r;
    end
  end

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
  import wmm_pkg::*;

  typedef struct packed {
    logic matched;
    logic overflow;
  } verdict_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  wmm_in_if  in_bus ();
  wmm_out_if out_bus ();

  wildcard_mask_matcher_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_bus.sink),
    .out_ch    (out_bus.source)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Mirror of the matcher state
  logic [7:0] mask_byte_q [MASK_MAX];
  kind_t      mask_kind_q [MASK_MAX];
  int         mask_len_q;
  logic       esc_q;
  logic       ovf_q;
  logic       in_subj_q;
  logic       fold_en_q;
  pos_vec_t   reach_q;

  verdict_t expected_verdicts[$];

  int src_idle_pct;
  int sink_stall_pct;
  logic hold_req;
  int hold_len;
  int hold_left;

  int items_sent;
  int results_checked;
  int ovf_results;
  int fail_cnt;

  function automatic logic [7:0] fold_case(logic [7:0] c);
    if (fold_en_q && c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      return c + CASE_OFFSET;
    end
    return c;
  endfunction

  // A reached star also reaches the position after it; ascending order closes runs.
  function automatic pos_vec_t close_star_runs(pos_vec_t v);
    pos_vec_t r;
    r = v;
    for (int i = 0; i < mask_len_q; i++) begin
      if (r[i] && mask_kind_q[i] == KIND_STAR) begin
        r[i+1] = 1'b1;
      end
    end
    return r;
  endfunction

  task automatic push_verdict();
    verdict_t v;
    v.matched  = reach_q[mask_len_q] && !esc_q && !ovf_q;
    v.overflow = ovf_q;
    expected_verdicts.push_back(v);
    in_subj_q = 1'b0;
    if (ovf_q) begin
      ovf_results++;
    end
  endtask

  task automatic predict_match(op_t op, logic [7:0] c, logic last);
    pos_vec_t nxt;
    kind_t k;
    case (op)
      OP_CLEAR: begin
        mask_len_q = 0;
        esc_q      = 1'b0;
        ovf_q      = 1'b0;
        reach_q    = '0;
        in_subj_q  = 1'b0;
      end
      OP_APPEND: begin
        // drop any subject in progress
        in_subj_q = 1'b0;
        reach_q   = '0;
        if (!esc_q && c == CHAR_BACKSLASH) begin
          esc_q = 1'b1;
        end else begin
          if (esc_q) begin
            k = KIND_LIT;
          end else if (c == CHAR_STAR) begin
            k = KIND_STAR;
          end else if (c == CHAR_ANY) begin
            k = KIND_ANY;
          end else begin
            k = KIND_LIT;
          end
          esc_q = 1'b0;
          if (mask_len_q >= MASK_MAX) begin
            ovf_q = 1'b1;
          end else begin
            mask_kind_q[mask_len_q] = k;
            mask_byte_q[mask_len_q] = c;
            mask_len_q++;
          end
        end
      end
      OP_SUBJECT: begin
        if (!in_subj_q) begin
          reach_q   = close_star_runs(pos_vec_t'(1));
          in_subj_q = 1'b1;
        end
        nxt = '0;
        for (int i = 0; i < mask_len_q; i++) begin
          if (reach_q[i]) begin
            case (mask_kind_q[i])
              KIND_STAR: nxt[i] = 1'b1;
              KIND_ANY:  nxt[i+1] = 1'b1;
              default: begin
                if (fold_case(mask_byte_q[i]) == fold_case(c)) begin
                  nxt[i+1] = 1'b1;
                end
              end
            endcase
          end
        end
        reach_q = close_star_runs(nxt);
        if (last) begin
          push_verdict();
        end
      end
      default: begin
        reach_q = close_star_runs(pos_vec_t'(1));
        push_verdict();
      end
    endcase
  endtask

  task automatic log_failure(string msg);
    if (fail_cnt < 10) begin
      $display("[%0t] %s", $time, msg);
    end
    fail_cnt++;
  endtask

  always @(posedge clk) begin : check_results
    verdict_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      results_checked++;
      if (expected_verdicts.size() == 0) begin
        log_failure($sformatf("unexpected result: matched=%0b overflow=%0b",
                              out_bus.matched, out_bus.pattern_overflow));
      end else begin
        want = expected_verdicts.pop_front();
        if (out_bus.matched !== want.matched) begin
          log_failure($sformatf("matched: expected %0b, got %0b",
                                want.matched, out_bus.matched));
        end
        if (out_bus.pattern_overflow !== want.overflow) begin
          log_failure($sformatf("pattern_overflow: expected %0b, got %0b",
                                want.overflow, out_bus.pattern_overflow));
        end
      end
    end
  end

  // Result side: random stalls, plus a long hold on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = hold_len;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Call at a falling edge; returns at the falling edge after acceptance with valid held.
  task automatic send_item(op_t op, logic [7:0] c, logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.op        <= op;
    in_bus.char_byte <= c;
    in_bus.is_last   <= last;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    predict_match(op, c, last);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    in_bus.valid <= 1'b0;
    while (expected_verdicts.size() != 0 && guard < 50000) begin
      @(negedge clk);
      guard++;
    end
    // let any mask transaction still in flight settle
    repeat (4) @(negedge clk);
  endtask

  task automatic write_fold(logic v);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    fold_en_q = v;
  endtask

  function automatic logic [7:0] text_byte();
    case ($urandom_range(11))
      0, 1:    return "a";
      2:       return "b";
      3:       return "A";
      4:       return "B";
      5:       return CHAR_STAR;
      6:       return CHAR_ANY;
      7:       return CHAR_BACKSLASH;
      8:       return "/";
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic test_directed();
    send_item(OP_EMPTY, 8'hFF, 1'b1);
    send_item(OP_SUBJECT, 8'h00, 1'b1);
    send_item(OP_CLEAR, 8'hFF, 1'b1);
    send_item(OP_APPEND, "a", 1'b0);
    send_item(OP_APPEND, CHAR_STAR, 1'b1);
    send_item(OP_APPEND, CHAR_BACKSLASH, 1'b0);
    send_item(OP_APPEND, CHAR_STAR, 1'b1);
    send_item(OP_APPEND, CHAR_ANY, 1'b0);
    send_item(OP_SUBJECT, "a", 1'b0);
    send_item(OP_SUBJECT, "/", 1'b0);
    send_item(OP_SUBJECT, CHAR_STAR, 1'b0);
    send_item(OP_SUBJECT, 8'hFF, 1'b1);
    send_item(OP_SUBJECT, "A", 1'b1);
    // mask byte mid-subject drops the subject
    send_item(OP_SUBJECT, "a", 1'b0);
    send_item(OP_APPEND, ".", 1'b1);
    // empty subject mid-subject replaces it
    send_item(OP_SUBJECT, "a", 1'b0);
    send_item(OP_EMPTY, 8'h00, 1'b0);
    // dangling escape blocks every match
    send_item(OP_APPEND, CHAR_BACKSLASH, 1'b1);
    send_item(OP_EMPTY, 8'h55, 1'b0);
    send_item(OP_SUBJECT, "a", 1'b1);
    send_item(OP_APPEND, CHAR_STAR, 1'b0);
    send_item(OP_CLEAR, 8'h00, 1'b0);
    send_item(OP_APPEND, "A", 1'b0);
    write_fold(1'b1);
    send_item(OP_SUBJECT, "a", 1'b1);
    send_item(OP_SUBJECT, "A", 1'b1);
    send_item(OP_SUBJECT, "b", 1'b1);
    write_fold(1'b0);
    send_item(OP_SUBJECT, "a", 1'b1);
  endtask

  task automatic test_mask_overflow();
    send_item(OP_CLEAR, 8'h00, 1'b1);
    for (int i = 0; i < MASK_MAX - 1; i++) begin
      send_item(OP_APPEND, (i % 4 == 1) ? CHAR_ANY : "a", i[0]);
    end
    send_item(OP_APPEND, CHAR_STAR, 1'b0);
    send_item(OP_EMPTY, 8'h00, 1'b1);
    // escaped element with no room left
    send_item(OP_APPEND, CHAR_BACKSLASH, 1'b0);
    send_item(OP_APPEND, CHAR_STAR, 1'b0);
    send_item(OP_SUBJECT, "a", 1'b1);
    send_item(OP_EMPTY, 8'hFF, 1'b1);
    send_item(OP_CLEAR, 8'h00, 1'b0);
    send_item(OP_EMPTY, 8'h00, 1'b0);
  endtask

  task automatic test_backpressure();
    int saved_idle;
    saved_idle = src_idle_pct;
    send_item(OP_CLEAR, 8'h00, 1'b0);
    send_item(OP_APPEND, CHAR_STAR, 1'b0);
    send_item(OP_APPEND, "z", 1'b1);
    src_idle_pct = 0;
    hold_len = 300;
    hold_req = 1'b1;
    for (int i = 0; i < 24; i++) begin
      send_item(OP_SUBJECT, (i % 3 == 0) ? "z" : text_byte(), 1'b1);
    end
    // pause the sender until the backlog has gone
    wait_drained();
    for (int i = 0; i < 6; i++) begin
      send_item(i[0] ? OP_EMPTY : OP_SUBJECT, "z", 1'b1);
    end
    src_idle_pct = saved_idle;
  endtask

  task automatic run_sequence();
    kind_t kinds[$];
    logic [7:0] chars[$];
    logic [7:0] subj[$];
    int n_elem;
    int pick;
    logic [7:0] c;
    if ($urandom_range(9) != 0) begin
      send_item(OP_CLEAR, 8'($urandom_range(255)), 1'($urandom_range(1)));
    end
    n_elem = ($urandom_range(9) == 0) ? $urandom_range(36, 28) : $urandom_range(8, 0);
    repeat (n_elem) begin
      pick = $urandom_range(99);
      if (pick < 20) begin
        kinds.push_back(KIND_STAR);
        chars.push_back(CHAR_STAR);
        send_item(OP_APPEND, CHAR_STAR, 1'($urandom_range(1)));
      end else if (pick < 35) begin
        kinds.push_back(KIND_ANY);
        chars.push_back(CHAR_ANY);
        send_item(OP_APPEND, CHAR_ANY, 1'($urandom_range(1)));
      end else begin
        c = (pick < 45) ? 8'($urandom_range(255)) : text_byte();
        if (pick < 45 || c == CHAR_STAR || c == CHAR_ANY || c == CHAR_BACKSLASH) begin
          send_item(OP_APPEND, CHAR_BACKSLASH, 1'($urandom_range(1)));
        end
        kinds.push_back(KIND_LIT);
        chars.push_back(c);
        send_item(OP_APPEND, c, 1'($urandom_range(1)));
      end
    end
    if ($urandom_range(19) == 0) begin
      send_item(OP_APPEND, CHAR_BACKSLASH, 1'($urandom_range(1)));
    end
    repeat ($urandom_range(4, 1)) begin
      subj.delete();
      if ($urandom_range(3) != 0) begin
        // build a subject that the mask should accept, then maybe spoil it
        for (int i = 0; i < kinds.size(); i++) begin
          case (kinds[i])
            KIND_STAR: repeat ($urandom_range(3)) subj.push_back(text_byte());
            KIND_ANY:  subj.push_back(8'($urandom_range(255)));
            default: begin
              c = chars[i];
              if ((c | 8'h20) >= "a" && (c | 8'h20) <= "z" && $urandom_range(3) == 0) begin
                c = c ^ 8'h20;
              end
              subj.push_back(c);
            end
          endcase
        end
        if (subj.size() != 0 && $urandom_range(4) == 0) begin
          subj[$urandom_range(subj.size() - 1)] = text_byte();
        end
      end else begin
        repeat ($urandom_range(10)) subj.push_back(text_byte());
      end
      if (subj.size() == 0) begin
        send_item(OP_EMPTY, 8'($urandom_range(255)), 1'($urandom_range(1)));
      end else begin
        for (int i = 0; i < subj.size(); i++) begin
          if (i == subj.size() - 1) begin
            send_item(OP_SUBJECT, subj[i], 1'b1);
          end else begin
            send_item(OP_SUBJECT, subj[i], 1'b0);
            if ($urandom_range(49) == 0) begin
              // break the subject off
              case ($urandom_range(2))
                0:       send_item(OP_CLEAR, 8'($urandom_range(255)), 1'($urandom_range(1)));
                1:       send_item(OP_APPEND, text_byte(), 1'($urandom_range(1)));
                default: send_item(OP_EMPTY, 8'($urandom_range(255)), 1'($urandom_range(1)));
              endcase
              break;
            end
          end
        end
      end
    end
  endtask

  task automatic test_random_traffic(int n_items);
    int stop_at;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      if ($urandom_range(99) < 12) begin
        send_item(op_t'($urandom_range(3)), 8'($urandom_range(255)),
                  1'($urandom_range(1)));
      end else begin
        run_sequence();
      end
    end
  endtask

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = 1'b0;
    in_bus.valid     = 1'b0;
    in_bus.op        = OP_CLEAR;
    in_bus.char_byte = 8'h00;
    in_bus.is_last   = 1'b0;
    out_bus.ready    = 1'b0;
    hold_req         = 1'b0;
    hold_len         = 0;
    hold_left        = 0;
    items_sent       = 0;
    results_checked  = 0;
    ovf_results      = 0;
    fail_cnt         = 0;
    mask_len_q       = 0;
    esc_q            = 1'b0;
    ovf_q            = 1'b0;
    in_subj_q        = 1'b0;
    fold_en_q        = 1'b0;
    reach_q          = '0;
    src_idle_pct     = 20;
    sink_stall_pct   = 87;

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    write_fold(1'b0);
    test_directed();
    test_mask_overflow();
    test_backpressure();
    test_random_traffic(240);
    write_fold(1'b1);
    test_random_traffic(240);

    src_idle_pct   = 87;
    sink_stall_pct = 20;
    test_random_traffic(240);
    write_fold(1'b0);
    test_random_traffic(240);

    src_idle_pct   = 0;
    sink_stall_pct = 0;
    test_random_traffic(240);
    write_fold(1'b1);
    test_random_traffic(240);

    wait_drained();
    repeat (8) @(negedge clk);
    if (expected_verdicts.size() != 0) begin
      log_failure($sformatf("%0d results never arrived", expected_verdicts.size()));
    end
    $display("Sent %0d transactions; checked %0d results, %0d of them on an overflowed mask.",
             items_sent, results_checked, ovf_results);
    $display("Case folding off and on, three idle/stall profiles and a long output hold.");
    if (fail_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
